// ----- rtl/core/swdh_pkg.sv -----
// Shared types and constants for the serial wire debug host engine.
`default_nettype none
package swdh_pkg;

   // Command codes
   localparam logic [1:0] CMD_READ   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_SWITCH = 2'd2;
   localparam logic [1:0] CMD_FLUSH  = 2'd3;

   // Completion status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_FAULT  = 3'd1;
   localparam logic [2:0] ST_UNKACK = 3'd2;
   localparam logic [2:0] ST_PARITY = 3'd3;
   localparam logic [2:0] ST_RETRY  = 3'd4;

   // Acknowledge codes, first received bit in bit 0
   localparam logic [2:0] ACK_OK    = 3'b001;
   localparam logic [2:0] ACK_WAIT  = 3'b010;
   localparam logic [2:0] ACK_FAULT = 3'b100;

   // Line switch word, sent LSB first
   localparam logic [15:0] SWITCH_WORD = 16'hE79E;

   // Phase codes of the transaction sequencer
   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_HDR   = 4'd1;
   localparam logic [3:0] PH_TURN1 = 4'd2;
   localparam logic [3:0] PH_ACK   = 4'd3;
   localparam logic [3:0] PH_TURNA = 4'd4;
   localparam logic [3:0] PH_TURN2 = 4'd5;
   localparam logic [3:0] PH_WDATA = 4'd6;
   localparam logic [3:0] PH_WPAR  = 4'd7;
   localparam logic [3:0] PH_RDATA = 4'd8;
   localparam logic [3:0] PH_RPAR  = 4'd9;
   localparam logic [3:0] PH_TRAIL = 4'd10;
   localparam logic [3:0] PH_SW1   = 4'd11;
   localparam logic [3:0] PH_SWW   = 4'd12;
   localparam logic [3:0] PH_SW2   = 4'd13;
   localparam logic [3:0] PH_SWZ   = 4'd14;
   localparam logic [3:0] PH_FLUSH = 4'd15;

   // Register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [0:0]  REG_WAIT_RETRY_LIMIT = 1'b0;

   typedef struct packed {
      logic        start_req;
      logic [1:0]  command;
      logic        ap_select;
      logic [1:0]  reg_bits;
      logic [31:0] write_data;
      logic        swdio_in;
   } req_payload_type;

   typedef struct packed {
      logic        clock_pulse;
      logic        swdio_out;
      logic        swdio_drive;
      logic        busy_res;
      logic        done_res;
      logic [2:0]  status;
      logic [2:0]  ack_code;
      logic [31:0] read_data;
   } rsp_payload_type;

endpackage
`default_nettype wire

// ----- rtl/core/swdh_csr.sv -----
// Configuration register block: wait retry limit behind an APB-style port.
`default_nettype none
module swdh_csr
   import swdh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output logic [15:0]                wait_retry_limit
);

   logic [15:0] limit_ff;
   logic [15:0] limit_in;
   logic        wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[CSR_ADDR_W-1] == REG_WAIT_RETRY_LIMIT);

   // Write path
   always_comb begin
      limit_in = limit_ff;
      if (wr_hit) begin
         limit_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 16'd0;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Read decode
   always_comb begin
      unique case (csr_paddr[CSR_ADDR_W-1])
         REG_WAIT_RETRY_LIMIT: csr_prdata = {16'd0, limit_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   assign wait_retry_limit = limit_ff;

endmodule
`default_nettype wire

// ----- rtl/core/swd_host_transaction_engine.sv -----
// Serial wire debug host: one bit cycle per accepted request, result register on the output.
// Latency: a request's response is valid in the cycle after the request is accepted.
// Throughput: one request per clock when not stalled; the sequencer steps once per request.
// The output register frees the input side whenever it is empty or being taken.
// Reset (synchronous, active high) puts the sequencer idle, clears its state and
// sets the wait retry limit to 0 (retry without limit).
`default_nettype none
module swd_host_transaction_engine
   import swdh_pkg::*;
#(
   parameter int unsigned SWITCH_ONES = 100,
   parameter int unsigned IDLE_ZEROS  = 20,
   parameter int unsigned FLUSH_BITS  = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_payload_type       req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam logic [6:0] SW_ONES_LAST  = 7'(SWITCH_ONES - 1);
   localparam logic [6:0] IDLE_Z_LAST   = 7'(IDLE_ZEROS - 1);
   localparam logic [6:0] FLUSH_LAST    = 7'(FLUSH_BITS - 1);

   logic [15:0] wait_retry_limit;

   swdh_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .wait_retry_limit (wait_retry_limit)
   );

   // Sequencer state
   logic [3:0]  phase_ff,     phase_in;
   logic [6:0]  bit_count_ff, bit_count_in;
   logic [31:0] shift_word_ff, shift_word_in;
   logic        parity_ff,    parity_in;
   logic [1:0]  command_ff,   command_in;
   logic [2:0]  header_ff,    header_in;
   logic [2:0]  ack_ff,       ack_in;
   logic [15:0] retry_ff,     retry_in;

   // Output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // One bit cycle of the transaction
   always_comb begin
      logic [3:0]  ph;
      logic [6:0]  bc;
      logic [31:0] sw;
      logic        pa;
      logic [1:0]  cmd;
      logic [2:0]  hdr;
      logic [7:0]  hdr_bits;
      logic        rnw;
      logic        dout;
      logic        clk_p;
      logic        drv;
      logic        done;
      logic [2:0]  st;
      logic [31:0] rd;

      ph  = phase_ff;
      bc  = bit_count_ff;
      sw  = shift_word_ff;
      pa  = parity_ff;
      cmd = command_ff;
      hdr = header_ff;
      retry_in = retry_ff;
      ack_in   = ack_ff;
      clk_p = 1'b0;
      dout  = 1'b0;
      drv   = 1'b0;
      done  = 1'b0;
      st    = ST_OK;
      rd    = 32'd0;

      // Start of a new transaction
      if (phase_ff == PH_IDLE && req_payload.start_req) begin
         cmd = req_payload.command;
         hdr = {req_payload.reg_bits, req_payload.ap_select};
         sw  = (req_payload.command == CMD_WRITE) ? req_payload.write_data : 32'd0;
         retry_in = 16'd0;
         bc  = 7'd0;
         pa  = 1'b0;
         case (req_payload.command)
            CMD_READ, CMD_WRITE: ph = PH_HDR;
            CMD_SWITCH:          ph = PH_SW1;
            default:             ph = PH_FLUSH;
         endcase
      end

      rnw = (cmd == CMD_READ);
      // start, APnDP, RnW, A2, A3, parity, stop, park (bit 0 first)
      hdr_bits = {1'b1, 1'b0, hdr[0] ^ rnw ^ hdr[1] ^ hdr[2], hdr[2], hdr[1],
                  rnw, hdr[0], 1'b1};

      phase_in      = ph;
      bit_count_in  = bc;
      shift_word_in = sw;
      parity_in     = pa;
      command_in    = cmd;
      header_in     = hdr;

      if (ph != PH_IDLE) begin
         clk_p = 1'b1;
         unique case (ph)
            PH_HDR: begin
               drv  = 1'b1;
               dout = hdr_bits[bc[2:0]];
               bit_count_in = bc + 7'd1;
               if (bc == 7'd7) begin
                  bit_count_in = 7'd0;
                  phase_in     = PH_TURN1;
               end
            end
            PH_TURN1: begin
               ack_in       = 3'd0;
               bit_count_in = 7'd0;
               phase_in     = PH_ACK;
            end
            PH_ACK: begin
               ack_in = ack_ff | ({2'b00, req_payload.swdio_in} << bc[1:0]);
               bit_count_in = bc + 7'd1;
               if (bc == 7'd2) begin
                  bit_count_in = 7'd0;
                  parity_in    = 1'b0;
                  if (ack_in == ACK_OK) begin
                     phase_in = (cmd == CMD_WRITE) ? PH_TURN2 : PH_RDATA;
                  end else begin
                     phase_in = PH_TURNA;
                  end
               end
            end
            PH_TURNA: begin
               if (ack_ff == ACK_WAIT &&
                   (wait_retry_limit == 16'd0 || retry_ff < wait_retry_limit)) begin
                  retry_in     = retry_ff + 16'd1;
                  bit_count_in = 7'd0;
                  phase_in     = PH_HDR;
               end else begin
                  done = 1'b1;
                  if (ack_ff == ACK_WAIT) begin
                     st = ST_RETRY;
                  end else if (ack_ff == ACK_FAULT) begin
                     st = ST_FAULT;
                  end else begin
                     st = ST_UNKACK;
                  end
                  phase_in = PH_IDLE;
               end
            end
            PH_TURN2: begin
               bit_count_in = 7'd0;
               phase_in     = PH_WDATA;
            end
            PH_WDATA: begin
               drv  = 1'b1;
               dout = sw[bc[4:0]];
               parity_in    = pa ^ dout;
               bit_count_in = bc + 7'd1;
               if (bc == 7'd31) begin
                  bit_count_in = 7'd0;
                  phase_in     = PH_WPAR;
               end
            end
            PH_WPAR: begin
               drv      = 1'b1;
               dout     = pa;
               done     = 1'b1;
               phase_in = PH_IDLE;
            end
            PH_RDATA: begin
               shift_word_in[bc[4:0]] = sw[bc[4:0]] | req_payload.swdio_in;
               parity_in    = pa ^ req_payload.swdio_in;
               bit_count_in = bc + 7'd1;
               if (bc == 7'd31) begin
                  bit_count_in = 7'd0;
                  phase_in     = PH_RPAR;
               end
            end
            PH_RPAR: begin
               parity_in = pa ^ req_payload.swdio_in;
               if (parity_in) begin
                  shift_word_in = 32'd0;
               end
               phase_in = PH_TRAIL;
            end
            PH_TRAIL: begin
               done     = 1'b1;
               st       = pa ? ST_PARITY : ST_OK;
               rd       = pa ? 32'd0 : sw;
               phase_in = PH_IDLE;
            end
            PH_SW1: begin
               drv  = 1'b1;
               dout = 1'b1;
               bit_count_in = bc + 7'd1;
               if (bc == SW_ONES_LAST) begin
                  bit_count_in = 7'd0;
                  phase_in     = PH_SWW;
               end
            end
            PH_SWW: begin
               drv  = 1'b1;
               dout = SWITCH_WORD[bc[3:0]];
               bit_count_in = bc + 7'd1;
               if (bc == 7'd15) begin
                  bit_count_in = 7'd0;
                  phase_in     = PH_SW2;
               end
            end
            PH_SW2: begin
               drv  = 1'b1;
               dout = 1'b1;
               bit_count_in = bc + 7'd1;
               if (bc == SW_ONES_LAST) begin
                  bit_count_in = 7'd0;
                  phase_in     = PH_SWZ;
               end
            end
            PH_SWZ: begin
               drv = 1'b1;
               bit_count_in = bc + 7'd1;
               if (bc == IDLE_Z_LAST) begin
                  bit_count_in = 7'd0;
                  done         = 1'b1;
                  phase_in     = PH_IDLE;
               end
            end
            default: begin
               // flush: driven zeros
               drv = 1'b1;
               bit_count_in = bc + 7'd1;
               if (bc == FLUSH_LAST) begin
                  bit_count_in = 7'd0;
                  done         = 1'b1;
                  phase_in     = PH_IDLE;
               end
            end
         endcase
      end

      rsp_payload_in.clock_pulse = clk_p;
      rsp_payload_in.swdio_out   = dout;
      rsp_payload_in.swdio_drive = drv;
      rsp_payload_in.busy_res    = (phase_in != PH_IDLE);
      rsp_payload_in.done_res    = done;
      rsp_payload_in.status      = st;
      rsp_payload_in.ack_code    = ack_in;
      rsp_payload_in.read_data   = rd;
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State advances once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= 7'd0;
         shift_word_ff <= 32'd0;
         parity_ff     <= 1'b0;
         command_ff    <= CMD_READ;
         header_ff     <= 3'd0;
         ack_ff        <= 3'd0;
         retry_ff      <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            shift_word_ff <= shift_word_in;
            parity_ff     <= parity_in;
            command_ff    <= command_in;
            header_ff     <= header_in;
            ack_ff        <= ack_in;
            retry_ff      <= retry_in;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire

// ----- verif/swd_host_transaction_engine_tb.sv -----
// Self-checking testbench for the serial wire debug host transaction engine.
module swd_host_transaction_engine_tb;
   import swdh_pkg::*;

   localparam int unsigned SWITCH_ONES  = 100;
   localparam int unsigned IDLE_ZEROS   = 20;
   localparam int unsigned FLUSH_BITS   = 8;
   localparam int          LONG_HOLDOFF = 60;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * REG_WAIT_RETRY_LIMIT);

   // Acknowledge patterns outside the three defined codes
   localparam logic [2:0] ACK_NONE     = 3'b000;
   localparam logic [2:0] ACK_ALL_ONES = 3'b111;
   localparam logic [2:0] ACK_OK_WAIT  = 3'b011;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   swd_host_transaction_engine #(
      .SWITCH_ONES (SWITCH_ONES),
      .IDLE_ZEROS  (IDLE_ZEROS),
      .FLUSH_BITS  (FLUSH_BITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Sequencer mirror, advanced once per accepted request
   logic [3:0]  seq_phase = PH_IDLE;
   logic [6:0]  seq_bit_count = '0;
   logic [31:0] seq_shift = '0;
   logic        seq_parity = 1'b0;
   logic [1:0]  seq_cmd = CMD_READ;
   logic [2:0]  seq_header = '0;
   logic [2:0]  seq_ack = '0;
   logic [15:0] seq_retries = '0;
   logic [15:0] retry_limit = '0;

   rsp_payload_type predicted_cycles[$];
   logic [2:0]      ack_plan[$];

   int   err_count = 0;
   int   txn_items = 0;
   int   txn_count = 0;
   int   cycles_checked = 0;
   int   completions[0:7];
   bit   idling_on = 1'b1;
   bit   holdoff_req = 1'b0;
   int   stall_left = 0;

   // One bit cycle of the host: returns the expected response and updates the mirror
   function automatic rsp_payload_type step_sequencer(input req_payload_type rq);
      rsp_payload_type r;
      logic [7:0]      hdr;
      logic            rnw;
      r = '0;
      if (seq_phase == PH_IDLE && rq.start_req) begin
         seq_cmd       = rq.command;
         seq_header    = {rq.reg_bits, rq.ap_select};
         seq_shift     = (rq.command == CMD_WRITE) ? rq.write_data : 32'h0;
         seq_retries   = '0;
         seq_bit_count = '0;
         seq_parity    = 1'b0;
         if (rq.command == CMD_READ || rq.command == CMD_WRITE) seq_phase = PH_HDR;
         else if (rq.command == CMD_SWITCH) seq_phase = PH_SW1;
         else seq_phase = PH_FLUSH;
      end
      if (seq_phase != PH_IDLE) begin
         r.clock_pulse = 1'b1;
         case (seq_phase)
            PH_HDR: begin
               // start, APnDP, RnW, A2, A3, parity, stop, park
               rnw = (seq_cmd == CMD_READ);
               hdr = {1'b1, 1'b0, ^{seq_header, rnw}, seq_header[2], seq_header[1], rnw,
                      seq_header[0], 1'b1};
               r.swdio_drive = 1'b1;
               r.swdio_out   = hdr[seq_bit_count[2:0]];
               seq_bit_count++;
               if (seq_bit_count >= 8) begin
                  seq_bit_count = '0;
                  seq_phase     = PH_TURN1;
               end
            end
            PH_TURN1: begin
               seq_ack       = '0;
               seq_bit_count = '0;
               seq_phase     = PH_ACK;
            end
            PH_ACK: begin
               if (rq.swdio_in) seq_ack[seq_bit_count[1:0]] = 1'b1;
               seq_bit_count++;
               if (seq_bit_count >= 3) begin
                  seq_bit_count = '0;
                  seq_parity    = 1'b0;
                  if (seq_ack == ACK_OK) seq_phase = (seq_cmd == CMD_WRITE) ? PH_TURN2 : PH_RDATA;
                  else seq_phase = PH_TURNA;
               end
            end
            PH_TURNA: begin
               if (seq_ack == ACK_WAIT && (retry_limit == 0 || seq_retries < retry_limit)) begin
                  seq_retries++;
                  seq_bit_count = '0;
                  seq_phase     = PH_HDR;
               end else begin
                  r.done_res = 1'b1;
                  if (seq_ack == ACK_WAIT) r.status = ST_RETRY;
                  else if (seq_ack == ACK_FAULT) r.status = ST_FAULT;
                  else r.status = ST_UNKACK;
                  seq_phase = PH_IDLE;
               end
            end
            PH_TURN2: begin
               seq_bit_count = '0;
               seq_phase     = PH_WDATA;
            end
            PH_WDATA: begin
               r.swdio_drive = 1'b1;
               r.swdio_out   = seq_shift[seq_bit_count[4:0]];
               seq_parity    = seq_parity ^ r.swdio_out;
               seq_bit_count++;
               if (seq_bit_count >= 32) begin
                  seq_bit_count = '0;
                  seq_phase     = PH_WPAR;
               end
            end
            PH_WPAR: begin
               r.swdio_drive = 1'b1;
               r.swdio_out   = seq_parity;
               r.done_res    = 1'b1;
               seq_phase     = PH_IDLE;
            end
            PH_RDATA: begin
               if (rq.swdio_in) seq_shift[seq_bit_count[4:0]] = 1'b1;
               seq_parity = seq_parity ^ rq.swdio_in;
               seq_bit_count++;
               if (seq_bit_count >= 32) begin
                  seq_bit_count = '0;
                  seq_phase     = PH_RPAR;
               end
            end
            PH_RPAR: begin
               seq_parity = seq_parity ^ rq.swdio_in;
               if (seq_parity) seq_shift = '0;
               seq_phase = PH_TRAIL;
            end
            PH_TRAIL: begin
               // trailing turnaround is done even after a parity error
               r.done_res  = 1'b1;
               r.status    = seq_parity ? ST_PARITY : ST_OK;
               r.read_data = seq_parity ? 32'h0 : seq_shift;
               seq_phase   = PH_IDLE;
            end
            PH_SW1, PH_SW2: begin
               r.swdio_drive = 1'b1;
               r.swdio_out   = 1'b1;
               seq_bit_count++;
               if (seq_bit_count >= SWITCH_ONES) begin
                  seq_bit_count = '0;
                  seq_phase     = (seq_phase == PH_SW1) ? PH_SWW : PH_SWZ;
               end
            end
            PH_SWW: begin
               r.swdio_drive = 1'b1;
               r.swdio_out   = SWITCH_WORD[seq_bit_count[3:0]];
               seq_bit_count++;
               if (seq_bit_count >= 16) begin
                  seq_bit_count = '0;
                  seq_phase     = PH_SW2;
               end
            end
            PH_SWZ: begin
               r.swdio_drive = 1'b1;
               seq_bit_count++;
               if (seq_bit_count >= IDLE_ZEROS) begin
                  seq_bit_count = '0;
                  r.done_res    = 1'b1;
                  seq_phase     = PH_IDLE;
               end
            end
            PH_FLUSH: begin
               r.swdio_drive = 1'b1;
               seq_bit_count++;
               if (seq_bit_count >= FLUSH_BITS) begin
                  seq_bit_count = '0;
                  r.done_res    = 1'b1;
                  seq_phase     = PH_IDLE;
               end
            end
            default: ;
         endcase
      end
      r.busy_res = (seq_phase != PH_IDLE);
      r.ack_code = seq_ack;
      return r;
   endfunction

   function automatic req_payload_type random_payload();
      req_payload_type p;
      p.start_req  = 1'($urandom_range(0, 1));
      p.command    = 2'($urandom_range(0, 3));
      p.ap_select  = 1'($urandom_range(0, 1));
      p.reg_bits   = 2'($urandom_range(0, 3));
      p.write_data = $urandom;
      p.swdio_in   = 1'($urandom_range(0, 1));
      return p;
   endfunction

   // Send one request; called and returns just after a falling edge
   task automatic issue_tick(input req_payload_type p);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_payload = p;
      req_valid   = 1'b1;
      do @(posedge clock); while (req_stall);
      predicted_cycles.push_back(step_sequencer(p));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic idle_ticks(input int n);
      req_payload_type p;
      repeat (n) begin
         p = random_payload();
         p.start_req = 1'b0;
         issue_tick(p);
      end
   endtask

   // Run one transaction to completion, playing the target side on swdio_in.
   // Acknowledges come from ack_plan (OK once it runs dry); noise drives random levels.
   task automatic run_transaction(input logic [1:0] cmd, input logic ap, input logic [1:0] regb,
                                  input logic [31:0] wdata, input logic [31:0] rword,
                                  input logic bad_parity, input logic noise);
      req_payload_type p;
      logic [2:0]      cur_ack;
      cur_ack     = ACK_OK;
      p           = random_payload();
      p.start_req = 1'b1;
      p.command   = cmd;
      p.ap_select = ap;
      p.reg_bits  = regb;
      p.write_data = wdata;
      txn_count++;
      txn_items++;
      issue_tick(p);
      while (seq_phase != PH_IDLE) begin
         // start_req stays random: a request while busy must be ignored
         p = random_payload();
         if (!noise) begin
            case (seq_phase)
               PH_ACK: begin
                  if (seq_bit_count == 0) begin
                     if (ack_plan.size() != 0) cur_ack = ack_plan.pop_front();
                     else cur_ack = ACK_OK;
                  end
                  p.swdio_in = cur_ack[seq_bit_count[1:0]];
               end
               PH_RDATA: p.swdio_in = rword[seq_bit_count[4:0]];
               PH_RPAR:  p.swdio_in = ^rword ^ bad_parity;
               default: ;
            endcase
         end
         txn_items++;
         issue_tick(p);
      end
      ack_plan.delete();
   endtask

   task automatic wait_drained();
      while (predicted_cycles.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // One APB access: setup then access phase; reads are checked against the mirror
   task automatic csr_access(input logic is_write, input logic [31:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = is_write;
      csr_paddr   = LIMIT_ADDR;
      csr_pwdata  = is_write ? value : 32'h0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (is_write) begin
         retry_limit = value[15:0];
      end else if (csr_prdata !== {16'h0, retry_limit}) begin
         $display("%0t: retry limit readback: expected 0x%0h, got 0x%0h",
                  $time, {16'h0, retry_limit}, csr_prdata);
         err_count++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_retry_limit(input logic [31:0] value);
      wait_drained();
      csr_access(1'b1, value);
      csr_access(1'b0, 32'h0);
   endtask

   // Result side: random stall bursts, plus a long hold-off on request
   always @(negedge clock) begin
      if (holdoff_req) begin
         holdoff_req = 1'b0;
         stall_left  = LONG_HOLDOFF;
      end
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (idling_on && !reset && $urandom_range(0, 5) == 0) begin
         rsp_stall  = 1'b1;
         stall_left = $urandom_range(1, 7) - 1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
         err_count++;
      end
   endtask

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin : rsp_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_cycles.size() == 0) begin
            $display("%0t: unexpected response 0x%0h", $time, rsp_payload);
            err_count++;
         end else begin
            want = predicted_cycles.pop_front();
            cycles_checked++;
            if (want.done_res) completions[want.status]++;
            check_field("clock_pulse", want.clock_pulse, rsp_payload.clock_pulse);
            check_field("swdio_out", want.swdio_out, rsp_payload.swdio_out);
            check_field("swdio_drive", want.swdio_drive, rsp_payload.swdio_drive);
            check_field("busy_res", want.busy_res, rsp_payload.busy_res);
            check_field("done_res", want.done_res, rsp_payload.done_res);
            check_field("status", want.status, rsp_payload.status);
            check_field("ack_code", want.ack_code, rsp_payload.ack_code);
            check_field("read_data", want.read_data, rsp_payload.read_data);
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_register_access();
      csr_access(1'b0, 32'h0);
      // upper bits of the write data are dropped
      set_retry_limit(32'hA5A5_FFFF);
      set_retry_limit(32'h0);
   endtask

   task automatic test_idle_and_flush();
      idle_ticks(3);
      run_transaction(CMD_FLUSH, 1'b0, 2'd0, 32'h0, 32'h0, 1'b0, 1'b0);
      idle_ticks(2);
   endtask

   task automatic test_line_switch();
      run_transaction(CMD_SWITCH, 1'b1, 2'd3, $urandom, 32'h0, 1'b0, 1'b0);
   endtask

   task automatic test_write_transfers();
      run_transaction(CMD_WRITE, 1'b0, 2'd0, 32'h0000_0000, 32'h0, 1'b0, 1'b0);
      run_transaction(CMD_WRITE, 1'b1, 2'd3, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
   endtask

   task automatic test_read_transfers();
      run_transaction(CMD_READ, 1'b0, 2'd2, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0);
      run_transaction(CMD_READ, 1'b1, 2'd0, 32'h0, 32'h0000_0000, 1'b0, 1'b0);
      // parity mismatch: zero data, parity error after the trailing turnaround
      run_transaction(CMD_READ, 1'b0, 2'd1, 32'h0, $urandom, 1'b1, 1'b0);
   endtask

   task automatic test_ack_errors();
      ack_plan.push_back(ACK_FAULT);
      run_transaction(CMD_READ, 1'b1, 2'd2, 32'h0, $urandom, 1'b0, 1'b0);
      ack_plan.push_back(ACK_NONE);
      run_transaction(CMD_WRITE, 1'b0, 2'd3, $urandom, 32'h0, 1'b0, 1'b0);
      ack_plan.push_back(ACK_ALL_ONES);
      run_transaction(CMD_READ, 1'b0, 2'd0, 32'h0, $urandom, 1'b0, 1'b0);
      ack_plan.push_back(ACK_OK_WAIT);
      run_transaction(CMD_WRITE, 1'b1, 2'd2, $urandom, 32'h0, 1'b0, 1'b0);
   endtask

   task automatic test_wait_retries();
      // limit reached: third WAIT ends the transfer
      set_retry_limit(32'd2);
      repeat (3) ack_plan.push_back(ACK_WAIT);
      run_transaction(CMD_READ, 1'b1, 2'd1, 32'h0, $urandom, 1'b0, 1'b0);
      set_retry_limit(32'd1);
      ack_plan.push_back(ACK_WAIT);
      run_transaction(CMD_WRITE, 1'b0, 2'd2, $urandom, 32'h0, 1'b0, 1'b0);
      // unlimited retries
      set_retry_limit(32'd0);
      repeat (3) ack_plan.push_back(ACK_WAIT);
      run_transaction(CMD_READ, 1'b0, 2'd3, 32'h0, $urandom, 1'b0, 1'b0);
      set_retry_limit(32'd65535);
      repeat (2) ack_plan.push_back(ACK_WAIT);
      ack_plan.push_back(ACK_FAULT);
      run_transaction(CMD_WRITE, 1'b1, 2'd0, $urandom, 32'h0, 1'b0, 1'b0);
   endtask

   task automatic test_backpressure();
      holdoff_req = 1'b1;
      run_transaction(CMD_WRITE, 1'b1, 2'd1, $urandom, 32'h0, 1'b0, 1'b0);
      run_transaction(CMD_READ, 1'b0, 2'd2, 32'h0, $urandom, 1'b0, 1'b0);
   endtask

   task automatic random_transaction();
      int         pick;
      int         nwait;
      logic [1:0] cmd;
      pick = $urandom_range(0, 99);
      if (pick < 45) cmd = CMD_READ;
      else if (pick < 90) cmd = CMD_WRITE;
      else if (pick < 98) cmd = CMD_FLUSH;
      else cmd = CMD_SWITCH;
      nwait = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 4) : 0;
      repeat (nwait) ack_plan.push_back(ACK_WAIT);
      pick = $urandom_range(0, 9);
      if (pick < 8) ack_plan.push_back(ACK_OK);
      else if (pick == 8) ack_plan.push_back(ACK_FAULT);
      else ack_plan.push_back(3'($urandom));
      run_transaction(cmd, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom,
                      $urandom, $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
   endtask

   task automatic test_random_traffic(input int budget, input logic [31:0] limit);
      int first;
      set_retry_limit(limit);
      first = txn_items;
      while (txn_items - first < budget) begin
         random_transaction();
         idle_ticks($urandom_range(0, 2));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_access();
      test_idle_and_flush();
      test_line_switch();
      test_write_transfers();
      test_read_transfers();
      test_ack_errors();
      test_wait_retries();
      test_backpressure();
      test_random_traffic(25, 32'd1);
      test_random_traffic(25, 32'd0);
      // closing stretch runs without random request gaps or result stalls
      idling_on = 1'b0;
      test_random_traffic(25, $urandom_range(2, 5));

      wait_drained();
      repeat (8) @(negedge clock);
      $display("Checked %0d bit-cycle responses over %0d transactions (%0d transaction cycles)",
               cycles_checked, txn_count, txn_items);
      $display("Completions: ok %0d, fault %0d, unknown ack %0d, parity %0d, retry limit %0d",
               completions[ST_OK], completions[ST_FAULT], completions[ST_UNKACK],
               completions[ST_PARITY], completions[ST_RETRY]);
      if (err_count == 0 && predicted_cycles.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #400000;
      $display("Verification failed");
      $finish;
   end

endmodule
